// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the quaternion converter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication checked on every rising edge outside reset.
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent in this cycle, consequent from the next cycle on.
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rmq_pkg.sv =====
// Shared types and constants of the rotation matrix to quaternion converter.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FIELD_W   = 18;
    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // Side information that travels with each word down the pipeline.
    typedef struct packed {
        logic [1:0] big;    // component taken from the square root
        logic [3:0] neg;    // sign of each component, w in bit 0
        logic       degen;  // radicand was clamped
    } t_tag;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, Shepperd's method, fully pipelined.
// Words run from start to o_strobe in order; one word is taken every cycle while busy is low.
// The depth is set by two digit-by-digit square roots (18 and 31 stages) and
// two restoring dividers (26 and 17 stages), one bit per stage.
// Synchronous active-low reset empties the pipeline; busy is high only in reset.
// The receiver cannot stall, so results leave on o_strobe without back pressure.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [FIELD_W-1:0] i_m00,
    input  logic signed [FIELD_W-1:0] i_m01,
    input  logic signed [FIELD_W-1:0] i_m02,
    input  logic signed [FIELD_W-1:0] i_m10,
    input  logic signed [FIELD_W-1:0] i_m11,
    input  logic signed [FIELD_W-1:0] i_m12,
    input  logic signed [FIELD_W-1:0] i_m20,
    input  logic signed [FIELD_W-1:0] i_m21,
    input  logic signed [FIELD_W-1:0] i_m22,
    output logic                      o_strobe,
    output logic signed [FIELD_W-1:0] o_qw,
    output logic signed [FIELD_W-1:0] o_qx,
    output logic signed [FIELD_W-1:0] o_qy,
    output logic signed [FIELD_W-1:0] o_qz,
    output logic                      o_degenerate
);

    localparam int TR_W    = FIELD_W + 2;
    localparam int RADS_W  = FIELD_W + 3;
    localparam int RAD_W   = FIELD_W + 1;
    localparam int SQ1_IN  = RAD_W + FRAC_BITS;
    localparam int R1      = (SQ1_IN + 1) / 2;
    localparam int SQ1_W   = 2 * R1;
    localparam int DMAG_W  = FIELD_W + 1;
    localparam int DNUM_W  = DMAG_W + FRAC_BITS;
    localparam int DV_W    = R1 + 1;
    // The divisor 2s is at least 2^(FRAC_BITS/2+1), so the top bits of the
    // numerator above the quotient always stay below it.
    localparam int QW1     = DNUM_W - (FRAC_BITS / 2 + 1);
    localparam int MAG_W   = QW1;
    localparam int MSB_W   = $clog2(MAG_W);
    localparam int NORM_MSB = 29;
    localparam int NRM_W   = NORM_MSB + 1;
    localparam int SH_W    = $clog2(NORM_MSB + 1);
    localparam int SQR_W   = 2 * NRM_W;
    localparam int SUM_W   = SQR_W + 2;
    localparam int R2      = SUM_W / 2;
    localparam int QW2     = FRAC_BITS + 1;
    localparam int ENUM_W  = NRM_W + FRAC_BITS + 1;
    localparam int LAT     = 12 + R1 + QW1 + R2 + QW2;

    localparam logic signed [RADS_W-1:0]  ONE_R = RADS_W'(ONE);
    localparam logic signed [FIELD_W-1:0] ONE_F = FIELD_W'(ONE);
    localparam logic [QW2-1:0]            ONE_Q = QW2'(ONE);

    logic accept;

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // ---------------------------------------------------------------- stage A
    logic signed [FIELD_W-1:0] r_a_m [0:8];
    logic                      r_a_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
        end
        r_a_m[0] <= i_m00;
        r_a_m[1] <= i_m01;
        r_a_m[2] <= i_m02;
        r_a_m[3] <= i_m10;
        r_a_m[4] <= i_m11;
        r_a_m[5] <= i_m12;
        r_a_m[6] <= i_m20;
        r_a_m[7] <= i_m21;
        r_a_m[8] <= i_m22;
    end

    // ---------------------------------------------------------------- stage B
    // Trace and choice of the largest diagonal entry (earlier axis wins ties).
    logic signed [FIELD_W-1:0] r_b_m [0:8];
    logic signed [TR_W-1:0]    r_b_tr;
    logic [1:0]                r_b_i;
    logic                      r_b_vld;
    logic signed [TR_W-1:0]    n_b_tr;
    logic [1:0]                n_b_i;
    logic signed [FIELD_W-1:0] dsel;
    logic                      gt10;

    always_comb begin
        n_b_tr = TR_W'(r_a_m[0]) + TR_W'(r_a_m[4]) + TR_W'(r_a_m[8]);
        gt10   = r_a_m[4] > r_a_m[0];
        dsel   = gt10 ? r_a_m[4] : r_a_m[0];
        if (r_a_m[8] > dsel) begin
            n_b_i = 2'd2;
        end else begin
            n_b_i = gt10 ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_m  <= r_a_m;
        r_b_tr <= n_b_tr;
        r_b_i  <= n_b_i;
    end

    // ---------------------------------------------------------------- stage C
    logic [SQ1_W-1:0]  r_s_x    [0:R1];
    logic [R1+1:0]     r_s_rem  [0:R1];
    logic [R1-1:0]     r_s_root [0:R1];
    logic [DMAG_W-1:0] r_s_dmag [0:R1][0:2];
    t_tag              r_s_tag  [0:R1];
    logic              r_s_vld  [0:R1];

    logic                      pos;
    logic signed [FIELD_W-1:0] mii;
    logic signed [RADS_W-1:0]  rad;
    logic                      n_c_degen;
    logic [RAD_W-1:0]          n_c_rad;
    logic signed [TR_W-1:0]    dv0, dv1, dv2;
    logic [DMAG_W-1:0]         n_c_dmag [0:2];
    t_tag                      n_c_tag;

    always_comb begin
        pos = !r_b_tr[TR_W-1] && (r_b_tr != '0);
        unique case (r_b_i)
            2'd0:    mii = r_b_m[0];
            2'd1:    mii = r_b_m[4];
            default: mii = r_b_m[8];
        endcase
        // Off the positive-trace branch, m_ii - (m_jj + m_kk) = 2 m_ii - trace.
        if (pos) begin
            rad = RADS_W'(r_b_tr) + ONE_R;
        end else begin
            rad = (RADS_W'(mii) <<< 1) - RADS_W'(r_b_tr) + ONE_R;
        end
        n_c_degen = !pos && (rad[RADS_W-1] || (rad == '0));
        n_c_rad   = n_c_degen ? RAD_W'(1) : rad[RAD_W-1:0];

        if (pos) begin
            n_c_tag.big = 2'd0;
            dv0 = TR_W'(r_b_m[5]) - TR_W'(r_b_m[7]);
            dv1 = TR_W'(r_b_m[6]) - TR_W'(r_b_m[2]);
            dv2 = TR_W'(r_b_m[1]) - TR_W'(r_b_m[3]);
            n_c_tag.neg = {dv2[TR_W-1], dv1[TR_W-1], dv0[TR_W-1], 1'b0};
        end else begin
            unique case (r_b_i)
                2'd0: begin
                    n_c_tag.big = 2'd1;
                    dv0 = TR_W'(r_b_m[5]) - TR_W'(r_b_m[7]);
                    dv1 = TR_W'(r_b_m[1]) + TR_W'(r_b_m[3]);
                    dv2 = TR_W'(r_b_m[2]) + TR_W'(r_b_m[6]);
                    n_c_tag.neg = {dv2[TR_W-1], dv1[TR_W-1], 1'b0, dv0[TR_W-1]};
                end
                2'd1: begin
                    n_c_tag.big = 2'd2;
                    dv0 = TR_W'(r_b_m[6]) - TR_W'(r_b_m[2]);
                    dv1 = TR_W'(r_b_m[3]) + TR_W'(r_b_m[1]);
                    dv2 = TR_W'(r_b_m[5]) + TR_W'(r_b_m[7]);
                    n_c_tag.neg = {dv2[TR_W-1], 1'b0, dv1[TR_W-1], dv0[TR_W-1]};
                end
                default: begin
                    n_c_tag.big = 2'd3;
                    dv0 = TR_W'(r_b_m[1]) - TR_W'(r_b_m[3]);
                    dv1 = TR_W'(r_b_m[6]) + TR_W'(r_b_m[2]);
                    dv2 = TR_W'(r_b_m[7]) + TR_W'(r_b_m[5]);
                    n_c_tag.neg = {1'b0, dv2[TR_W-1], dv1[TR_W-1], dv0[TR_W-1]};
                end
            endcase
        end
        n_c_tag.degen = n_c_degen;
        n_c_dmag[0] = dv0[TR_W-1] ? DMAG_W'(-dv0) : DMAG_W'(dv0);
        n_c_dmag[1] = dv1[TR_W-1] ? DMAG_W'(-dv1) : DMAG_W'(dv1);
        n_c_dmag[2] = dv2[TR_W-1] ? DMAG_W'(-dv2) : DMAG_W'(dv2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld[0] <= 1'b0;
        end else begin
            r_s_vld[0] <= r_b_vld;
        end
        r_s_x[0]    <= SQ1_W'({n_c_rad, {FRAC_BITS{1'b0}}});
        r_s_rem[0]  <= '0;
        r_s_root[0] <= '0;
        r_s_dmag[0] <= n_c_dmag;
        r_s_tag[0]  <= n_c_tag;
    end

    // ------------------------------------------- first square root, 1 bit/stage
    for (genvar t = 0; t < R1; t++) begin : g_sq1
        logic [R1+3:0] rem2;
        logic [R1+3:0] trial;
        logic [R1+3:0] diff;
        logic          ge;

        always_comb begin
            rem2  = {r_s_rem[t], r_s_x[t][SQ1_W-1-2*t -: 2]};
            trial = (R1+4)'({r_s_root[t], 2'b01});
            diff  = rem2 - trial;
            ge    = rem2 >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[t+1] <= 1'b0;
            end else begin
                r_s_vld[t+1] <= r_s_vld[t];
            end
            r_s_x[t+1]    <= r_s_x[t];
            r_s_rem[t+1]  <= ge ? diff[R1+1:0] : rem2[R1+1:0];
            r_s_root[t+1] <= {r_s_root[t][R1-2:0], ge};
            r_s_dmag[t+1] <= r_s_dmag[t];
            r_s_tag[t+1]  <= r_s_tag[t];
        end
    end

    // --------------------------------------------------- stage P, divider set-up
    logic [DV_W-1:0]   r_d_dv  [0:QW1];
    logic [DNUM_W-1:0] r_d_num [0:QW1][0:2];
    logic [DV_W-1:0]   r_d_rem [0:QW1][0:2];
    logic [QW1-1:0]    r_d_q   [0:QW1][0:2];
    logic [R1-1:0]     r_d_big [0:QW1];
    t_tag              r_d_tag [0:QW1];
    logic              r_d_vld [0:QW1];

    logic [R1-1:0]     sroot;
    logic [R1:0]       sinc;
    logic [DNUM_W-1:0] n_p_num [0:2];
    logic [DV_W-1:0]   n_p_rem [0:2];

    always_comb begin
        sroot = r_s_root[R1];
        sinc  = (R1+1)'(sroot) + (R1+1)'(1);
        for (int k = 0; k < 3; k++) begin
            n_p_num[k] = {r_s_dmag[R1][k], {FRAC_BITS{1'b0}}} + DNUM_W'(sroot);
            n_p_rem[k] = DV_W'(n_p_num[k][DNUM_W-1:QW1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else begin
            r_d_vld[0] <= r_s_vld[R1];
        end
        r_d_dv[0]  <= {sroot, 1'b0};
        r_d_num[0] <= n_p_num;
        r_d_rem[0] <= n_p_rem;
        r_d_q[0]   <= '{default: '0};
        r_d_big[0] <= sinc[R1:1];
        r_d_tag[0] <= r_s_tag[R1];
    end

    // ------------------------------------ three restoring dividers, 1 bit/stage
    for (genvar t = 0; t < QW1; t++) begin : g_div1
        logic [DV_W:0] rem2 [0:2];
        logic [DV_W:0] diff [0:2];
        logic          ge   [0:2];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                rem2[k] = {r_d_rem[t][k], r_d_num[t][k][QW1-1-t]};
                diff[k] = rem2[k] - {1'b0, r_d_dv[t]};
                ge[k]   = rem2[k] >= {1'b0, r_d_dv[t]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[t+1] <= 1'b0;
            end else begin
                r_d_vld[t+1] <= r_d_vld[t];
            end
            for (int k = 0; k < 3; k++) begin
                r_d_rem[t+1][k] <= ge[k] ? diff[k][DV_W-1:0] : rem2[k][DV_W-1:0];
                r_d_q[t+1][k]   <= {r_d_q[t][k][QW1-2:0], ge[k]};
            end
            r_d_dv[t+1]  <= r_d_dv[t];
            r_d_num[t+1] <= r_d_num[t];
            r_d_big[t+1] <= r_d_big[t];
            r_d_tag[t+1] <= r_d_tag[t];
        end
    end

    // ---------------------------------------- stage M, place the four components
    logic [MAG_W-1:0] r_m_mag [0:3];
    t_tag             r_m_tag;
    logic             r_m_vld;
    logic [MAG_W-1:0] n_m_mag [0:3];
    logic [MAG_W-1:0] bigm;

    always_comb begin
        bigm = MAG_W'(r_d_big[QW1]);
        unique case (r_d_tag[QW1].big)
            2'd0: n_m_mag = '{bigm, r_d_q[QW1][0], r_d_q[QW1][1], r_d_q[QW1][2]};
            2'd1: n_m_mag = '{r_d_q[QW1][0], bigm, r_d_q[QW1][1], r_d_q[QW1][2]};
            2'd2: n_m_mag = '{r_d_q[QW1][0], r_d_q[QW1][1], bigm, r_d_q[QW1][2]};
            default: n_m_mag = '{r_d_q[QW1][0], r_d_q[QW1][1], r_d_q[QW1][2], bigm};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_d_vld[QW1];
        end
        r_m_mag <= n_m_mag;
        r_m_tag <= r_d_tag[QW1];
    end

    // ---------------------------------------- stage L, common normalising shift
    // The largest magnitude has the same leading one as the OR of all four.
    logic [MAG_W-1:0] r_l_mag [0:3];
    logic [SH_W-1:0]  r_l_sh;
    t_tag             r_l_tag;
    logic             r_l_vld;
    logic [MAG_W-1:0] orm;
    logic [MSB_W-1:0] msb;

    always_comb begin
        orm = r_m_mag[0] | r_m_mag[1] | r_m_mag[2] | r_m_mag[3];
        msb = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (orm[b]) begin
                msb = MSB_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else begin
            r_l_vld <= r_m_vld;
        end
        r_l_mag <= r_m_mag;
        r_l_sh  <= SH_W'(NORM_MSB) - SH_W'(msb);
        r_l_tag <= r_m_tag;
    end

    // ---------------------------------------------------------------- stage H
    logic [NRM_W-1:0] r_h_mag [0:3];
    t_tag             r_h_tag;
    logic             r_h_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_l_vld;
        end
        for (int n = 0; n < 4; n++) begin
            r_h_mag[n] <= NRM_W'(r_l_mag[n]) << r_l_sh;
        end
        r_h_tag <= r_l_tag;
    end

    // ------------------------------------------ stages Q1 to Q3, sum of squares
    logic [SQR_W-1:0]   r_q1_sq  [0:3];
    logic [NRM_W-1:0]   r_q1_mag [0:3];
    t_tag               r_q1_tag;
    logic               r_q1_vld;
    logic [SQR_W:0]     r_q2_sum [0:1];
    logic [NRM_W-1:0]   r_q2_mag [0:3];
    t_tag               r_q2_tag;
    logic               r_q2_vld;

    logic [SUM_W-1:0] r_t_x    [0:R2];
    logic [R2+1:0]    r_t_rem  [0:R2];
    logic [R2-1:0]    r_t_root [0:R2];
    logic [NRM_W-1:0] r_t_mag  [0:R2][0:3];
    t_tag             r_t_tag  [0:R2];
    logic             r_t_vld  [0:R2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld   <= 1'b0;
            r_q2_vld   <= 1'b0;
            r_t_vld[0] <= 1'b0;
        end else begin
            r_q1_vld   <= r_h_vld;
            r_q2_vld   <= r_q1_vld;
            r_t_vld[0] <= r_q2_vld;
        end
        for (int n = 0; n < 4; n++) begin
            r_q1_sq[n] <= SQR_W'(r_h_mag[n]) * SQR_W'(r_h_mag[n]);
        end
        r_q1_mag    <= r_h_mag;
        r_q1_tag    <= r_h_tag;
        r_q2_sum[0] <= (SQR_W+1)'(r_q1_sq[0]) + (SQR_W+1)'(r_q1_sq[1]);
        r_q2_sum[1] <= (SQR_W+1)'(r_q1_sq[2]) + (SQR_W+1)'(r_q1_sq[3]);
        r_q2_mag    <= r_q1_mag;
        r_q2_tag    <= r_q1_tag;
        r_t_x[0]    <= SUM_W'(r_q2_sum[0]) + SUM_W'(r_q2_sum[1]);
        r_t_rem[0]  <= '0;
        r_t_root[0] <= '0;
        r_t_mag[0]  <= r_q2_mag;
        r_t_tag[0]  <= r_q2_tag;
    end

    // ------------------------------------------ second square root, the length
    for (genvar t = 0; t < R2; t++) begin : g_sq2
        logic [R2+3:0] rem2;
        logic [R2+3:0] trial;
        logic [R2+3:0] diff;
        logic          ge;

        always_comb begin
            rem2  = {r_t_rem[t], r_t_x[t][SUM_W-1-2*t -: 2]};
            trial = (R2+4)'({r_t_root[t], 2'b01});
            diff  = rem2 - trial;
            ge    = rem2 >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_t_vld[t+1] <= 1'b0;
            end else begin
                r_t_vld[t+1] <= r_t_vld[t];
            end
            r_t_x[t+1]    <= r_t_x[t];
            r_t_rem[t+1]  <= ge ? diff[R2+1:0] : rem2[R2+1:0];
            r_t_root[t+1] <= {r_t_root[t][R2-2:0], ge};
            r_t_mag[t+1]  <= r_t_mag[t];
            r_t_tag[t+1]  <= r_t_tag[t];
        end
    end

    // --------------------------------------------------- stage E, divider set-up
    logic [R2-1:0]     r_e_len [0:QW2];
    logic [ENUM_W-1:0] r_e_num [0:QW2][0:3];
    logic [R2-1:0]     r_e_rem [0:QW2][0:3];
    logic [QW2-1:0]    r_e_q   [0:QW2][0:3];
    t_tag              r_e_tag [0:QW2];
    logic              r_e_vld [0:QW2];

    logic [R2-1:0]     len;
    logic [ENUM_W-1:0] n_e_num [0:3];
    logic [R2-1:0]     n_e_rem [0:3];

    always_comb begin
        len = r_t_root[R2];
        for (int n = 0; n < 4; n++) begin
            n_e_num[n] = ENUM_W'({r_t_mag[R2][n], {FRAC_BITS{1'b0}}})
                       + ENUM_W'(len >> 1);
            n_e_rem[n] = R2'(n_e_num[n][ENUM_W-1:QW2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld[0] <= 1'b0;
        end else begin
            r_e_vld[0] <= r_t_vld[R2];
        end
        r_e_len[0] <= len;
        r_e_num[0] <= n_e_num;
        r_e_rem[0] <= n_e_rem;
        r_e_q[0]   <= '{default: '0};
        r_e_tag[0] <= r_t_tag[R2];
    end

    // ------------------------------------------- four dividers by the length
    for (genvar t = 0; t < QW2; t++) begin : g_div2
        logic [R2:0] rem2 [0:3];
        logic [R2:0] diff [0:3];
        logic        ge   [0:3];

        always_comb begin
            for (int n = 0; n < 4; n++) begin
                rem2[n] = {r_e_rem[t][n], r_e_num[t][n][QW2-1-t]};
                diff[n] = rem2[n] - {1'b0, r_e_len[t]};
                ge[n]   = rem2[n] >= {1'b0, r_e_len[t]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_e_vld[t+1] <= 1'b0;
            end else begin
                r_e_vld[t+1] <= r_e_vld[t];
            end
            for (int n = 0; n < 4; n++) begin
                r_e_rem[t+1][n] <= ge[n] ? diff[n][R2-1:0] : rem2[n][R2-1:0];
                r_e_q[t+1][n]   <= {r_e_q[t][n][QW2-2:0], ge[n]};
            end
            r_e_len[t+1] <= r_e_len[t];
            r_e_num[t+1] <= r_e_num[t];
            r_e_tag[t+1] <= r_e_tag[t];
        end
    end

    // ------------------------------------------------ output stage, sign and clamp
    logic signed [FIELD_W-1:0] r_out_q [0:3];
    logic                      r_out_degen;
    logic                      r_out_vld;
    logic signed [FIELD_W-1:0] n_out_q [0:3];
    logic [QW2-1:0]            qc      [0:3];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            qc[n] = (r_e_q[QW2][n] > ONE_Q) ? ONE_Q : r_e_q[QW2][n];
            n_out_q[n] = r_e_tag[QW2].neg[n] ? -FIELD_W'(qc[n]) : FIELD_W'(qc[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_e_vld[QW2];
        end
        r_out_q     <= n_out_q;
        r_out_degen <= r_e_tag[QW2].degen;
    end

    assign o_strobe     = r_out_vld;
    assign o_qw         = r_out_q[0];
    assign o_qx         = r_out_q[1];
    assign o_qy         = r_out_q[2];
    assign o_qz         = r_out_q[3];
    assign o_degenerate = r_out_degen;

    // ---------------------------------------------------------------- checks
    `RMQ_ASSERT_NEXT(a_word_arrives, i_clk, i_rst_n, accept, ##(LAT-1) o_strobe, "accepted word did not reach the output on time")
    `RMQ_ASSERT(a_no_phantom, i_clk, i_rst_n, o_strobe |-> $past(accept, LAT), "result strobe without an accepted word")
    `RMQ_ASSERT(a_unit_range, i_clk, i_rst_n, o_strobe |-> ((o_qw <= ONE_F) && (o_qw >= -ONE_F) && (o_qx <= ONE_F) && (o_qx >= -ONE_F) && (o_qy <= ONE_F) && (o_qy >= -ONE_F) && (o_qz <= ONE_F) && (o_qz >= -ONE_F)), "component outside the unit range")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the rotation matrix to quaternion converter.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; predicts each word in place.
`timescale 1ns / 1ps

module tb_top;
    import rmq_pkg::*;

    localparam int LATENCY   = 104;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1530;

    typedef logic signed [FIELD_W-1:0] t_fix;

    typedef struct {
        t_fix qw, qx, qy, qz;
        logic degen;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_fix m_in [9] = '{default: '0};
    logic o_strobe;
    t_fix o_qw, o_qx, o_qy, o_qz;
    logic o_degenerate;

    t_quat quat_queue[$];
    int    n_errors = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_degen = 0;
    int    idle_cycles = 0;
    bit    stall_en = 1'b1;

    always #1 i_clk = ~i_clk;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_m00(m_in[0]), .i_m01(m_in[1]), .i_m02(m_in[2]),
        .i_m10(m_in[3]), .i_m11(m_in[4]), .i_m12(m_in[5]),
        .i_m20(m_in[6]), .i_m21(m_in[7]), .i_m22(m_in[8]),
        .o_strobe(o_strobe), .o_qw(o_qw), .o_qx(o_qx), .o_qy(o_qy), .o_qz(o_qz),
        .o_degenerate(o_degenerate)
    );

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned round_quot(longint d, longint unsigned s, output bit sgn);
        longint unsigned a;
        sgn = d < 0;
        a = d < 0 ? -d : d;
        return ((a << FRAC_BITS) + s) / (2 * s);
    endfunction

    function automatic t_quat predict_quat(t_fix m [9]);
        longint mm [3][3];
        longint unsigned mag [4];
        bit sgn [4];
        longint trace, rad;
        longint unsigned s, maxm, n2, len, q;
        longint v;
        int i, j, k;
        t_fix comp [4];
        t_quat res;
        res.degen = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) mm[r][c] = m[r*3+c];
        trace = mm[0][0] + mm[1][1] + mm[2][2];
        if (trace > 0) begin
            rad = trace + ONE;
            s = int_sqrt(longint'(rad) << FRAC_BITS);
            mag[0] = (s + 1) >> 1;
            sgn[0] = 0;
            mag[1] = round_quot(mm[1][2] - mm[2][1], s, sgn[1]);
            mag[2] = round_quot(mm[2][0] - mm[0][2], s, sgn[2]);
            mag[3] = round_quot(mm[0][1] - mm[1][0], s, sgn[3]);
        end else begin
            i = 0;
            if (mm[1][1] > mm[0][0]) i = 1;
            if (mm[2][2] > mm[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = mm[i][i] - (mm[j][j] + mm[k][k]) + ONE;
            if (rad <= 0) begin
                rad = 1;
                res.degen = 1'b1;
            end
            s = int_sqrt(longint'(rad) << FRAC_BITS);
            mag[1+i] = (s + 1) >> 1;
            sgn[1+i] = 0;
            mag[0] = round_quot(mm[j][k] - mm[k][j], s, sgn[0]);
            mag[1+j] = round_quot(mm[i][j] + mm[j][i], s, sgn[1+j]);
            mag[1+k] = round_quot(mm[i][k] + mm[k][i], s, sgn[1+k]);
        end
        maxm = 0;
        for (int n = 0; n < 4; n++) if (mag[n] > maxm) maxm = mag[n];
        if (maxm != 0) begin
            while (maxm >= (64'd1 << 30)) begin
                for (int n = 0; n < 4; n++) mag[n] >>= 1;
                maxm >>= 1;
            end
            while (maxm < (64'd1 << 29)) begin
                for (int n = 0; n < 4; n++) mag[n] <<= 1;
                maxm <<= 1;
            end
        end
        n2 = 0;
        for (int n = 0; n < 4; n++) n2 += mag[n] * mag[n];
        len = int_sqrt(n2);
        for (int n = 0; n < 4; n++) begin
            v = 0;
            if (len != 0) begin
                q = ((mag[n] << FRAC_BITS) + (len >> 1)) / len;
                if (q > ONE) q = ONE;
                v = sgn[n] ? -longint'(q) : longint'(q);
            end
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            comp[n] = t_fix'(v);
        end
        res.qw = comp[0];
        res.qx = comp[1];
        res.qy = comp[2];
        res.qz = comp[3];
        return res;
    endfunction

    // Sends one matrix word, after a random pause when stall_en is set, and records its quaternion.
    // Start stays high across words sent with no pause in between.
    task automatic send_matrix(t_fix m [9]);
        int gap;
        gap = stall_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        m_in = m;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        quat_queue.push_back(predict_quat(m));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (quat_queue.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_strobe)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("%0t: watchdog expired with %0d words outstanding", $time,
                     quat_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_strobe) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected word qw=%0d qx=%0d qy=%0d qz=%0d", $time,
                         o_qw, o_qx, o_qy, o_qz);
                n_errors++;
            end else begin
                exp_q = quat_queue.pop_front();
                n_checked++;
                if (exp_q.degen) n_degen++;
                if (o_qw !== exp_q.qw || o_qx !== exp_q.qx || o_qy !== exp_q.qy ||
                    o_qz !== exp_q.qz || o_degenerate !== exp_q.degen) begin
                    $display("%0t: expected %0d %0d %0d %0d d%0b, got %0d %0d %0d %0d d%0b",
                             $time, exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.degen,
                             o_qw, o_qx, o_qy, o_qz, o_degenerate);
                    n_errors++;
                end
            end
        end
    end

    function automatic t_fix rand_entry();
        case ($urandom_range(0, 9))
            0: return t_fix'(ONE);
            1: return t_fix'(-ONE);
            2: return '0;
            3: return t_fix'($urandom);  // full 18-bit range, all bits toggle
            default: return t_fix'($signed($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    // A signed axis permutation, its entries scaled down by up to one half, keeps the trace
    // branches and every pivot axis in play; small noise perturbs it.
    function automatic void make_rotation(output t_fix m [9]);
        int perm [3];
        int t, a, b;
        perm = '{0, 1, 2};
        for (int n = 0; n < 3; n++) begin
            a = $urandom_range(0, 2);
            t = perm[n]; perm[n] = perm[a]; perm[a] = t;
        end
        for (int n = 0; n < 9; n++) m[n] = '0;
        for (int r = 0; r < 3; r++) begin
            b = $urandom_range(0, 1) ? ONE : -ONE;
            m[r*3+perm[r]] = t_fix'(b * (ONE - int'($urandom_range(0, ONE / 2))) / ONE);
        end
        for (int n = 0; n < 9; n++)
            if ($urandom_range(0, 2) == 0)
                m[n] = t_fix'(m[n] + $signed($urandom_range(0, 16384)) - 8192);
    endfunction

    task automatic test_directed();
        t_fix m [9];
        m = '{t_fix'(ONE), 0, 0, 0, t_fix'(ONE), 0, 0, 0, t_fix'(ONE)};
        send_matrix(m);
        m = '{t_fix'(ONE), 0, 0, 0, t_fix'(-ONE), 0, 0, 0, t_fix'(-ONE)};
        send_matrix(m);
        m = '{t_fix'(-ONE), 0, 0, 0, t_fix'(ONE), 0, 0, 0, t_fix'(-ONE)};
        send_matrix(m);
        m = '{t_fix'(-ONE), 0, 0, 0, t_fix'(-ONE), 0, 0, 0, t_fix'(ONE)};
        send_matrix(m);
        // Equal diagonal entries: the earlier axis wins.
        m = '{t_fix'(-ONE/2), 1, 2, 3, t_fix'(-ONE/2), 4, 5, 6, t_fix'(-ONE/2)};
        send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        // All diagonal entries at minus one, then a positive trace of one.
        m = '{t_fix'(-ONE), 0, 0, 0, t_fix'(-ONE), 0, 0, 0, t_fix'(-ONE)};
        send_matrix(m);
        m = '{0, t_fix'(ONE), 0, t_fix'(-ONE), 0, 0, 0, 0, t_fix'(ONE)};
        send_matrix(m);
        // Field extremes beyond one.
        for (int n = 0; n < 9; n++) m[n] = 18'sh1FFFF;
        send_matrix(m);
        for (int n = 0; n < 9; n++) m[n] = 18'sh20000;
        send_matrix(m);
        for (int n = 0; n < 9; n++) m[n] = (n % 2) ? 18'sh1FFFF : 18'sh20000;
        send_matrix(m);
        for (int n = 0; n < 9; n++) m[n] = (n % 4 == 0) ? 18'sh1 : 18'sh20000;
        send_matrix(m);
        m = '{t_fix'(ONE), t_fix'(ONE), t_fix'(-ONE), t_fix'(-ONE), t_fix'(ONE),
              t_fix'(ONE), t_fix'(ONE), t_fix'(-ONE), t_fix'(ONE)};
        send_matrix(m);
    endtask

    task automatic test_pause_drain();
        wait_drained();
    endtask

    task automatic test_random();
        t_fix m [9];
        for (int it = 0; it < N_RANDOM; it++) begin
            stall_en = (it / 200) % 3 != 2;
            if ($urandom_range(0, 3) != 0) make_rotation(m);
            else for (int n = 0; n < 9; n++) m[n] = rand_entry();
            send_matrix(m);
        end
        stall_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_pause_drain();
        test_random();
        wait_drained();
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("Sent %0d matrices, checked %0d quaternions (%0d degenerate).",
                 n_sent, n_checked, n_degen);
        if (n_errors == 0 && quat_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words outstanding", n_errors, quat_queue.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
